@@ sv/assert_macros.svh @@
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the scanner checker
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scanner checker assertion failed");

// clocked assertion, also checked during reset
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("scanner checker assertion failed");

`endif

@@ sv/mbps_pkg.sv @@
// ------------------------------------------------------------------------
// mbps_pkg
// shared types and constants of the masked byte pattern scanner
// ------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

    // fixed field widths
    localparam int ADDR_W    = 48;
    localparam int CNT_W     = 16;
    localparam int LEN_W     = 5;
    localparam int PAT_BYTES = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int OUT_W     = ADDR_W + CNT_W;

    // default window depth
    localparam int PATTERN_MAX_DEF = 16;

    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [ADDR_W-1:0] POS_MAX   = {ADDR_W{1'b1}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LOW   = 3'd0,
        CFG_PAT_HIGH  = 3'd1,
        CFG_CARE_MASK = 3'd2,
        CFG_PAT_LEN   = 3'd3,
        CFG_BASE_ADDR = 3'd4,
        CFG_MAX_MATCH = 3'd5
    } cfg_idx_t;

    typedef logic [PAT_BYTES-1:0][7:0] pat_t;

    // compare setup seen by every cell
    typedef struct packed {
        pat_t                 pattern;
        logic [PAT_BYTES-1:0] care;
        logic [LEN_W-1:0]     len;
    } cmp_t;

    // one result item
    typedef struct packed {
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic              done;
        logic [CNT_W-1:0]  total;
    } res_t;

endpackage

`default_nettype wire

@@ sv/mbps_cell.sv @@
// ------------------------------------------------------------------------
// mbps_cell
// one window byte: shifts toward the older end and compares its next byte
// ------------------------------------------------------------------------
`default_nettype none

module mbps_cell #(
    parameter int IDX = 0
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         shift_en,
    input  wire logic [7:0]   din,
    input  wire mbps_pkg::cmp_t cmp,
    output logic [7:0]        dout,
    output logic              mismatch
);
    import mbps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       active;
    logic [3:0] pat_idx;

    // shift in the neighbor's byte on every transfer
    always_comb
    begin
        byte_next = shift_en ? din : byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // this cell's byte lines up with pattern byte len-1-IDX
    always_comb
    begin
        active   = (int'(cmp.len) > IDX);
        pat_idx  = 4'(cmp.len - LEN_W'(IDX + 1));
        mismatch = active && cmp.care[pat_idx] && (din != cmp.pattern[pat_idx]);
    end

    assign dout = byte_reg;

endmodule

`default_nettype wire

@@ sv/mbps_out_queue.sv @@
// ------------------------------------------------------------------------
// mbps_out_queue
// two-entry result queue between the scan cells and the output stream
// ------------------------------------------------------------------------
`default_nettype none

module mbps_out_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mbps_pkg::res_t push_data,
    output logic                full,
    output logic                out_valid,
    input  wire logic           out_ready,
    output mbps_pkg::res_t      out_data
);
    import mbps_pkg::*;

    res_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = ent_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/masked_byte_pattern_scanner_core.sv @@
// ------------------------------------------------------------------------
// masked_byte_pattern_scanner_core
// wildcard byte signature scan over a streamed memory region
// ------------------------------------------------------------------------
// The block takes one byte per clock cycle, with no gaps of its own, while
// the output queue has room: the byte shifts into a row of PATTERN_MAX
// window cells and every cell below the pattern length compares its
// incoming byte against its pattern byte in the same cycle, so the match
// decision, the match count and the start address are ready at the edge
// that accepts the byte. A result (a match, the region's last byte, or
// both) is pushed into a two-entry output queue at that edge, so input only
// stalls when two results wait untaken. After reset it is ready at once.
`default_nettype none

module masked_byte_pattern_scanner_core #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [mbps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mbps_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  wire logic                          s_tlast,   // last_byte
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mbps_pkg::OUT_W-1:0]          m_tdata,  // [47:0] match_address,
                                                          // [63:48] match_total
    output logic                               m_tlast,   // scan_done
    output logic [0:0]                         m_tuser    // [0] match_valid
);
    import mbps_pkg::*;

    localparam int LEN_CAP = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

    // configuration registers
    logic [63:0]          pat_low_reg;
    logic [63:0]          pat_high_reg;
    logic [PAT_BYTES-1:0] care_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [CNT_W-1:0]     max_reg;

    // scan state
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic              stopped_reg, stopped_next;

    logic                   accept;
    logic                   q_full;
    cmp_t                   cmp;
    logic [LEN_W-1:0]       len_eff;
    logic [LEN_W-1:0]       len_m1;
    logic [PATTERN_MAX-1:0] mismatch;
    logic [7:0]             win [PATTERN_MAX];
    logic                   stop_eff;
    logic                   hit;
    logic [CNT_W-1:0]       found_new;
    logic                   stop_new;
    logic [ADDR_W-1:0]      start_off;
    res_t                   res;
    res_t                   out_res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            len_reg      <= LEN_W'(1);
            base_reg     <= '0;
            max_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_PAT_LOW:   pat_low_reg  <= cfg_data;
                CFG_PAT_HIGH:  pat_high_reg <= cfg_data;
                CFG_CARE_MASK: care_reg     <= cfg_data[PAT_BYTES-1:0];
                CFG_PAT_LEN:   len_reg      <= cfg_data[LEN_W-1:0];
                CFG_BASE_ADDR: base_reg     <= cfg_data[ADDR_W-1:0];
                CFG_MAX_MATCH: max_reg      <= cfg_data[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    // effective pattern length, clamped to one and to the cap
    always_comb
    begin
        if (len_reg == '0)
            len_eff = LEN_W'(1);
        else if (int'(len_reg) > LEN_CAP)
            len_eff = LEN_W'(LEN_CAP);
        else
            len_eff = len_reg;
        len_m1 = len_eff - LEN_W'(1);
    end

    assign cmp.pattern = {pat_high_reg, pat_low_reg};
    assign cmp.care    = care_reg;
    assign cmp.len     = len_eff;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !q_full;

    // window cells, cell 0 holds the newest byte
    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        mbps_cell #(
            .IDX (j)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .din      ((j == 0) ? s_tdata : win[(j == 0) ? 0 : j - 1]),
            .cmp      (cmp),
            .dout     (win[j]),
            .mismatch (mismatch[j])
        );
    end

    // match decision, count and start address
    always_comb
    begin
        stop_eff  = stopped_reg || ((max_reg != '0) && (found_reg >= max_reg));
        hit       = !stop_eff && (pos_reg >= ADDR_W'(len_m1)) && !(|mismatch);
        found_new = found_reg + CNT_W'(hit && (found_reg != COUNT_MAX));
        stop_new  = stop_eff || (hit && (max_reg != '0) && (found_new >= max_reg));
        start_off = pos_reg - ADDR_W'(len_m1);

        res.hit   = hit;
        res.addr  = hit ? (base_reg + start_off) : '0;
        res.done  = s_tlast;
        res.total = found_new;
    end

    // scan state update
    always_comb
    begin
        pos_next     = pos_reg;
        found_next   = found_reg;
        stopped_next = stopped_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_next     = '0;
                found_next   = '0;
                stopped_next = 1'b0;
            end
            else
            begin
                pos_next     = (pos_reg != POS_MAX) ? pos_reg + ADDR_W'(1) : pos_reg;
                found_next   = found_new;
                stopped_next = stop_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            found_reg   <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            found_reg   <= found_next;
            stopped_reg <= stopped_next;
        end
    end

    // result queue
    mbps_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (hit || s_tlast)),
        .push_data (res),
        .full      (q_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {out_res.total, out_res.addr};
    assign m_tlast = out_res.done;
    assign m_tuser = out_res.hit;

endmodule

`default_nettype wire

@@ sv/mbps_checker.sv @@
// ------------------------------------------------------------------------
// mbps_checker
// port-level checks of the scanner core, bound to the top level
// ------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mbps_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [mbps_pkg::OUT_W-1:0]     m_tdata,
    input wire logic                           m_tlast,
    input wire logic [0:0]                     m_tuser
);
    // a stalled result transfer holds its payload
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // a result without a match only comes from the region's last byte
    `ASSERT_CLK(a_nohit_is_done, m_tvalid && !m_tuser[0] |-> m_tlast)

    // a result without a match carries a zero address
    `ASSERT_CLK(a_nohit_addr_zero, m_tvalid && !m_tuser[0] |-> m_tdata[47:0] == 48'd0)

    // input only stalls while results wait at the output
    `ASSERT_ALWAYS(a_stall_needs_result, !s_tready |-> m_tvalid)

endmodule

bind masked_byte_pattern_scanner_core mbps_checker u_mbps_checker (.*);

`default_nettype wire

@@ test/tb_masked_byte_pattern_scanner_core.sv @@
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner_core
// Streams memory regions through the scanner and checks every result
// transfer against an in-bench model of the wildcard signature scan.
// Covers register extremes, the match limit, output backpressure and
// several idling mixes on both stream sides.
// ------------------------------------------------------------------------
module tb_masked_byte_pattern_scanner_core;
    import mbps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LEN_CAP = (PATTERN_MAX_DEF < 16) ? PATTERN_MAX_DEF : 16;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;
    logic [0:0]           m_tuser;

    // scanner model: registers
    logic [63:0]        pat_low;
    logic [63:0]        pat_high;
    logic [15:0]        care_bits;
    logic [LEN_W-1:0]   pat_len_reg;
    logic [ADDR_W-1:0]  base_addr;
    logic [CNT_W-1:0]   match_limit;

    // scanner model: scan state
    logic [7:0]         win_bytes [PATTERN_MAX_DEF];
    logic [ADDR_W-1:0]  scan_pos;
    logic [CNT_W-1:0]   hit_count;
    logic               scan_halted;

    res_t expected_scan_results [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_off_cycles;
    int items_sent;
    int results_checked;
    int match_results;
    int input_stall_cycles;
    int mismatch_count;

    masked_byte_pattern_scanner_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("[masked_byte_pattern_scanner_core] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // pattern length as the scanner applies it
    function automatic int unsigned active_length();
        int unsigned len;
        len = pat_len_reg;
        if (len == 0)
            len = 1;
        if (len > LEN_CAP)
            len = LEN_CAP;
        return len;
    endfunction

    // advance the model by one accepted byte and queue any result
    task automatic predict_scan_step(input logic [7:0] data_byte, input logic last_byte);
        int unsigned       len;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W:0]   pos_next;
        logic [127:0]      pat_all;
        res_t              r;
        int                i;
        int                k;
        len = active_length();
        pat_all = {pat_high, pat_low};
        hit = 1'b0;
        addr = '0;
        for (i = PATTERN_MAX_DEF - 1; i > 0; i--)
            win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = data_byte;
        if (match_limit != 0 && hit_count >= match_limit)
            scan_halted = 1'b1;
        pos_next = {1'b0, scan_pos} + 1'b1;
        // test only once the whole pattern lies inside the region
        if (!scan_halted && pos_next >= len)
        begin
            hit = 1'b1;
            for (k = 0; k < len; k++)
                if (care_bits[k] && win_bytes[len-1-k] != pat_all[k*8 +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                addr = base_addr + ADDR_W'(pos_next - len);
                if (hit_count != COUNT_MAX)
                    hit_count++;
                if (match_limit != 0 && hit_count >= match_limit)
                    scan_halted = 1'b1;
            end
        end
        if (scan_pos != POS_MAX)
            scan_pos++;
        if (hit || last_byte)
        begin
            r.hit   = hit;
            r.addr  = addr;
            r.done  = last_byte;
            r.total = hit_count;
            expected_scan_results = {expected_scan_results, r};
        end
        if (hit)
            match_results++;
        if (last_byte)
        begin
            scan_pos    = '0;
            hit_count   = '0;
            scan_halted = 1'b0;
        end
    endtask

    // result check
    always @(posedge clk)
    begin
        res_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_checked++;
            if (expected_scan_results.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                exp_r = expected_scan_results.pop_front();
                if (m_tuser[0] !== exp_r.hit)
                    report_mismatch($sformatf("match_valid %b, expected %b",
                                              m_tuser[0], exp_r.hit));
                if (m_tdata[ADDR_W-1:0] !== exp_r.addr)
                    report_mismatch($sformatf("match_address %h, expected %h",
                                              m_tdata[ADDR_W-1:0], exp_r.addr));
                if (m_tlast !== exp_r.done)
                    report_mismatch($sformatf("scan_done %b, expected %b",
                                              m_tlast, exp_r.done));
                if (m_tdata[OUT_W-1:ADDR_W] !== exp_r.total)
                    report_mismatch($sformatf("match_total %0d, expected %0d",
                                              m_tdata[OUT_W-1:ADDR_W], exp_r.total));
            end
        end
    end

    // input stall count
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && !s_tready)
            input_stall_cycles++;
    end

    // receiver: long hold-off first, else random stalls
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            m_tready = 1'b0;
            hold_off_cycles--;
        end
        else
            m_tready = ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        case (idx)
            CFG_PAT_LOW:   pat_low     = value;
            CFG_PAT_HIGH:  pat_high    = value;
            CFG_CARE_MASK: care_bits   = value[15:0];
            CFG_PAT_LEN:   pat_len_reg = value[LEN_W-1:0];
            CFG_BASE_ADDR: base_addr   = value[ADDR_W-1:0];
            CFG_MAX_MATCH: match_limit = value[CNT_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // one byte transfer, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] data_byte, input logic last_byte);
        @(negedge clk);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data_byte;
        s_tlast  = last_byte;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_scan_step(data_byte, last_byte);
        items_sent++;
    endtask

    // stop sending and wait until every expected result has come
    task automatic wait_scan_idle();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (expected_scan_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_scan_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_scan_results.size()));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int s_pct, input int r_pct);
        sender_idle_pct    = s_pct;
        receiver_stall_pct = r_pct;
    endtask

    // random register setup, with junk above the used bits at times
    task automatic randomize_setup();
        logic [63:0] junk;
        logic [15:0] care;
        logic [4:0]  len;
        logic [47:0] addr;
        logic [15:0] limit;
        junk = {$urandom, $urandom};
        if ($urandom_range(1) == 0)
            junk = '0;
        case ($urandom_range(3))
            0:       care = 16'hFFFF;
            1:       care = 16'h0000;
            default: care = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:       len = 5'($urandom_range(31));
            1, 2:    len = 5'($urandom_range(16, 9));
            default: len = 5'($urandom_range(8, 1));
        endcase
        addr = {16'($urandom), 32'($urandom)};
        if ($urandom_range(4) == 0)
            addr = POS_MAX - 48'($urandom_range(20));
        case ($urandom_range(11))
            0:          limit = 16'hFFFF;
            1, 2, 3:    limit = 16'($urandom_range(4, 1));
            default:    limit = '0;
        endcase
        write_register(CFG_PAT_LOW, {$urandom, $urandom});
        write_register(CFG_PAT_HIGH, {$urandom, $urandom});
        write_register(CFG_CARE_MASK, {junk[63:16], care});
        write_register(CFG_PAT_LEN, {junk[63:5], len});
        write_register(CFG_BASE_ADDR, {junk[63:48], addr});
        write_register(CFG_MAX_MATCH, {junk[63:16], limit});
        if ($urandom_range(7) == 0)
            write_register(CFG_UNUSED_IDX, {$urandom, $urandom});
    endtask

    // one region of random bytes, optionally with copies of the pattern
    task automatic send_region(input int n, input bit plant);
        logic [7:0]   region_bytes [];
        logic [127:0] pat_all;
        int           len;
        int           start;
        int           pick;
        int           i;
        int           k;
        region_bytes = new[n];
        pat_all = {pat_high, pat_low};
        len = active_length();
        for (i = 0; i < n; i++)
        begin
            pick = $urandom_range(15);
            if ($urandom_range(3) == 0)
                region_bytes[i] = pat_all[pick*8 +: 8];
            else
                region_bytes[i] = 8'($urandom);
        end
        if (plant && n >= len)
            repeat ($urandom_range(3, 1))
            begin
                start = $urandom_range(n - len);
                for (k = 0; k < len; k++)
                    if (care_bits[k])
                        region_bytes[start+k] = pat_all[k*8 +: 8];
            end
        for (i = 0; i < n; i++)
            send_byte(region_bytes[i], i == n - 1);
    endtask

    // reset register values: length one, all wildcard, so every byte hits
    task automatic test_reset_defaults();
        set_idling(0, 0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b1);
        wait_scan_idle();
    endtask

    // oversized length clamps to 16, all bytes cared, address wraps past the top
    task automatic test_length_and_address_extremes();
        int i;
        write_register(CFG_PAT_LOW, '1);
        write_register(CFG_PAT_HIGH, '1);
        write_register(CFG_CARE_MASK, 64'hFFFF);
        write_register(CFG_PAT_LEN, 64'd31);
        write_register(CFG_BASE_ADDR, {16'h0000, POS_MAX});
        write_register(CFG_MAX_MATCH, '0);
        for (i = 0; i < 17; i++)
            send_byte(8'hFF, i == 16);
        wait_scan_idle();
    endtask

    // zero length acts as one, limit lowered mid-region, region shorter than pattern
    task automatic test_limit_and_short_region();
        write_register(CFG_PAT_LOW, 64'hA5A5_A5A5_A5A5_A500);
        write_register(CFG_CARE_MASK, 64'h0001);
        write_register(CFG_PAT_LEN, 64'd0);
        write_register(CFG_BASE_ADDR, 64'h0000_1234_5678_0000);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_scan_idle();
        write_register(CFG_MAX_MATCH, 64'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_scan_idle();
        write_register(CFG_PAT_LEN, 64'd5);
        write_register(CFG_CARE_MASK, 64'h0000);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b1);
        wait_scan_idle();
    endtask

    // receiver holds off long enough for the output queue to fill
    task automatic test_backpressure();
        int i;
        set_idling(0, 0);
        write_register(CFG_PAT_LEN, 64'd1);
        write_register(CFG_CARE_MASK, 64'h0000);
        write_register(CFG_MAX_MATCH, 64'd0);
        hold_off_cycles = 300;
        for (i = 0; i < 40; i++)
            send_byte(8'($urandom), i == 39);
        wait_scan_idle();
    endtask

    // random regions under one idling mix, reconfigured every few regions
    task automatic test_random_regions(input int s_pct, input int r_pct,
                                       input int item_goal);
        int first_item;
        int n;
        set_idling(s_pct, r_pct);
        first_item = items_sent;
        while (items_sent - first_item < item_goal)
        begin
            wait_scan_idle();
            randomize_setup();
            repeat ($urandom_range(5, 2))
            begin
                if ($urandom_range(9) == 0)
                    n = $urandom_range(60, 25);
                else
                    n = $urandom_range(20, 1);
                send_region(n, $urandom_range(9) != 0);
            end
        end
        wait_scan_idle();
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PAT_LOW;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        items_sent = 0;
        results_checked = 0;
        match_results = 0;
        input_stall_cycles = 0;
        mismatch_count = 0;
        pat_low = '0;
        pat_high = '0;
        care_bits = '0;
        pat_len_reg = 5'd1;
        base_addr = '0;
        match_limit = '0;
        foreach (win_bytes[i])
            win_bytes[i] = '0;
        scan_pos = '0;
        hit_count = '0;
        scan_halted = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_length_and_address_extremes();
        test_limit_and_short_region();
        test_backpressure();
        test_random_regions(0, 0, 180);
        test_random_regions(53, 0, 180);
        test_random_regions(0, 53, 180);
        test_random_regions(27, 27, 180);

        $display("scanned %0d bytes, checked %0d results (%0d matches), input stalled %0d cycles",
                 items_sent, results_checked, match_results, input_stall_cycles);
        $display("covered register extremes, match limit, backpressure, idling mixes");
        if (mismatch_count == 0 && expected_scan_results.size() == 0)
            $display("[masked_byte_pattern_scanner_core] OK");
        else
            $display("[masked_byte_pattern_scanner_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_cell.sv
sv/mbps_out_queue.sv
sv/masked_byte_pattern_scanner_core.sv
sv/mbps_checker.sv
test/tb_masked_byte_pattern_scanner_core.sv
